[rtl/core/raid_stripe_parity_disk_locator_unit_defines.svh]
// Assertion macros for the RAID stripe parity-disk locator.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef RAID_STRIPE_PARITY_DISK_LOCATOR_UNIT_DEFINES_SVH
`define RAID_STRIPE_PARITY_DISK_LOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that holds outside reset.
`define RSPDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that holds at every edge, reset included.
`define RSPDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSPDL_ASSERT(lbl, prop, msg)
`define RSPDL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/core/rspdl_pkg.sv]
// Shared constants and helpers for the RAID stripe parity-disk locator.
// Has no dependencies; used by the interfaces and the top level.
package rspdl_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned TAG_W         = 32;
  localparam int unsigned DISK_OUT_W    = 4;
  localparam int unsigned MAX_DISKS_DEF = 16;

  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // A word is text when all four of its bytes are printable ASCII.
  function automatic logic word_is_text(input logic [DATA_W-1:0] w);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < DATA_W / 8; k++) begin
      if (w[8*k +: 8] < PRINT_LO || w[8*k +: 8] > PRINT_HI) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

[rtl/core/rspdl_if.sv]
// Valid/ready channel interfaces for the RAID stripe parity-disk locator.
// Depends on rspdl_pkg for field widths.
interface rspdl_in_if import rspdl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_word;
  logic              block_last;
  logic              disk_last;
  logic [TAG_W-1:0]  stripe_number;

  modport source (output valid, output data_word, output block_last,
                  output disk_last, output stripe_number, input ready);
  modport sink   (input valid, input data_word, input block_last,
                  input disk_last, input stripe_number, output ready);
endinterface

interface rspdl_out_if import rspdl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  parity_found;
  logic [DISK_OUT_W-1:0] parity_disk;
  logic [TAG_W-1:0]      stripe_tag;

  modport source (output valid, output parity_found, output parity_disk,
                  output stripe_tag, input ready);
  modport sink   (input valid, input parity_found, input parity_disk,
                  input stripe_tag, output ready);
endinterface

[rtl/core/raid_stripe_parity_disk_locator_unit.sv]
// RAID stripe parity-disk locator, top level. Depends on rspdl_pkg, the
// channel interfaces in rspdl_if.sv and the assertion macro header.
//
// The block scans a RAID stripe that arrives as 32-bit words, one disk block
// after another, and names the disk that probably holds parity. For each disk
// block it tracks whether every word matches the block's first word (a uniform
// block) and whether every byte is printable ASCII 0x20..0x7E (a text block).
// On the last word of the last disk it emits one result: parity_found is set
// when no block was uniform and exactly one block was non-text, and
// parity_disk then gives that block's disk index (zero otherwise); stripe_tag
// echoes the stripe number of that final word. A single-word block counts as
// uniform. disk_last is only looked at on a word that also has block_last set.
// Disk indexes saturate at MAX_DISKS-1 and are reported in four bits.
// Throughput is one word per cycle: each accepted word lands in an input
// register, and one compare, a byte range check and the per-stripe update
// run between that register and the result register, which takes the result
// of a stripe's final word as that word leaves the input register. The input
// side keeps taking words while a finished result waits in the output
// register; it only stalls when a second result is due before the first one
// has been taken.

`include "raid_stripe_parity_disk_locator_unit_defines.svh"

module raid_stripe_parity_disk_locator_unit
  import rspdl_pkg::*;
#(
  parameter int unsigned MAX_DISKS = MAX_DISKS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rspdl_in_if.sink     in_ch,
  rspdl_out_if.source  out_ch
);

  localparam int unsigned DISK_W = $clog2(MAX_DISKS);
  localparam logic [DISK_W-1:0] DISK_LAST_IDX = DISK_W'(MAX_DISKS - 1);

  // Input register.
  logic              s_valid_r;
  logic [DATA_W-1:0] s_word_r;
  logic              s_blk_last_r;
  logic              s_dsk_last_r;
  logic [TAG_W-1:0]  s_stripe_r;

  // Per-block and per-stripe scan state.
  logic              at_start_r, at_start_nxt;
  logic [DATA_W-1:0] first_r, first_nxt;
  logic              uniform_r, uniform_nxt;
  logic              text_r, text_nxt;
  logic [DISK_W-1:0] disk_idx_r, disk_idx_nxt;
  logic [1:0]        nt_cnt_r, nt_cnt_nxt;
  logic [DISK_W-1:0] cand_r, cand_nxt;
  logic              saw_unif_r, saw_unif_nxt;

  // Result register.
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [DISK_OUT_W-1:0] out_disk_r;
  logic [TAG_W-1:0]      out_tag_r;

  // Combinational view of the word in the input register.
  logic              uni_now;
  logic              text_now;
  logic              saw_blk;
  logic [1:0]        cnt_blk;
  logic [DISK_W-1:0] cand_blk;
  logic              found_blk;
  logic              makes_result;
  logic              advance;

  assign uni_now  = at_start_r | (uniform_r & (s_word_r == first_r));
  assign text_now = text_r & word_is_text(s_word_r);

  // What the stripe state looks like once this block has been closed.
  always_comb begin
    saw_blk  = saw_unif_r;
    cnt_blk  = nt_cnt_r;
    cand_blk = cand_r;
    if (uni_now) begin
      saw_blk = 1'b1;
    end else if (!text_now) begin
      if (nt_cnt_r != 2'd2) begin
        cnt_blk = nt_cnt_r + 2'd1;
      end
      cand_blk = disk_idx_r;
    end
  end

  assign found_blk = !saw_blk && (cnt_blk == 2'd1);

  // The stage moves on unless it would overwrite a result nobody has taken.
  assign makes_result = s_blk_last_r & s_dsk_last_r;
  assign advance      = s_valid_r & (!makes_result | !out_valid_r | out_ch.ready);
  assign in_ch.ready  = !s_valid_r | advance;

  always_comb begin
    at_start_nxt = at_start_r;
    first_nxt    = first_r;
    uniform_nxt  = uniform_r;
    text_nxt     = text_r;
    disk_idx_nxt = disk_idx_r;
    nt_cnt_nxt   = nt_cnt_r;
    cand_nxt     = cand_r;
    saw_unif_nxt = saw_unif_r;
    if (advance) begin
      if (!s_blk_last_r) begin
        at_start_nxt = 1'b0;
        first_nxt    = at_start_r ? s_word_r : first_r;
        uniform_nxt  = uni_now;
        text_nxt     = text_now;
      end else begin
        at_start_nxt = 1'b1;
        first_nxt    = '0;
        uniform_nxt  = 1'b1;
        text_nxt     = 1'b1;
        if (s_dsk_last_r) begin
          disk_idx_nxt = '0;
          nt_cnt_nxt   = 2'd0;
          cand_nxt     = '0;
          saw_unif_nxt = 1'b0;
        end else begin
          disk_idx_nxt = (disk_idx_r == DISK_LAST_IDX) ? disk_idx_r
                                                       : disk_idx_r + 1'b1;
          nt_cnt_nxt   = cnt_blk;
          cand_nxt     = cand_blk;
          saw_unif_nxt = saw_blk;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      at_start_r  <= 1'b1;
      first_r     <= '0;
      uniform_r   <= 1'b1;
      text_r      <= 1'b1;
      disk_idx_r  <= '0;
      nt_cnt_r    <= 2'd0;
      cand_r      <= '0;
      saw_unif_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s_valid_r <= in_ch.valid;
      end
      at_start_r <= at_start_nxt;
      first_r    <= first_nxt;
      uniform_r  <= uniform_nxt;
      text_r     <= text_nxt;
      disk_idx_r <= disk_idx_nxt;
      nt_cnt_r   <= nt_cnt_nxt;
      cand_r     <= cand_nxt;
      saw_unif_r <= saw_unif_nxt;
      if (advance && makes_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s_word_r     <= in_ch.data_word;
      s_blk_last_r <= in_ch.block_last;
      s_dsk_last_r <= in_ch.disk_last;
      s_stripe_r   <= in_ch.stripe_number;
    end
    if (advance && makes_result) begin
      out_found_r <= found_blk;
      out_disk_r  <= found_blk ? DISK_OUT_W'(cand_blk) : '0;
      out_tag_r   <= s_stripe_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.parity_found = out_found_r;
  assign out_ch.parity_disk  = out_disk_r;
  assign out_ch.stripe_tag   = out_tag_r;

  `RSPDL_ASSERT(a_cnt_saturates, nt_cnt_r != 2'd3, "non-text count passed two")
  `RSPDL_ASSERT(a_disk_zero_when_missing, out_valid_r && !out_found_r |-> out_disk_r == '0, "parity_disk nonzero without parity_found")
  `RSPDL_ASSERT(a_stripe_state_cleared, advance && makes_result |=> disk_idx_r == '0 && nt_cnt_r == 2'd0 && !saw_unif_r, "stripe state not cleared after result")
  `RSPDL_ASSERT(a_block_restarts, advance && s_blk_last_r |=> at_start_r && uniform_r && text_r, "block state not restarted after last word")
  `RSPDL_ASSERT(a_disk_idx_range, disk_idx_r <= DISK_LAST_IDX, "disk index beyond MAX_DISKS-1")

endmodule

[tb/testbench.sv]
// Self-checking bench for the RAID stripe parity-disk locator top level.
// Needs rspdl_pkg, the channel interfaces in rspdl_if.sv and the block's RTL.
// A table of hand-built stripes runs first, then random stripes checked against a predictor.
module testbench
  import rspdl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Disk indexes stop climbing here, as in the block's default build.
  localparam int unsigned MAX_DISKS = MAX_DISKS_DEF;
  // Words to push in the random part, after the table.
  localparam int unsigned RANDOM_WORDS = 1600;
  // One long receiver hold-off, long enough to back the block up into its input.
  localparam int unsigned HOLD_CYCLES = 300;
  // Drain length after the last expected result has arrived.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Cycles without any transfer on either channel before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk;
  logic rst_n;

  rspdl_in_if  in_ch ();
  rspdl_out_if out_ch ();

  raid_stripe_parity_disk_locator_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // One stripe verdict as it leaves the block.
  typedef struct packed {
    logic                  found;
    logic [DISK_OUT_W-1:0] disk;
    logic [TAG_W-1:0]      tag;
  } locate_t;

  // Scan state of the stripe under way: the per-block flags plus the
  // per-stripe tally of non-text and uniform blocks.
  typedef struct packed {
    logic              at_start;
    logic [DATA_W-1:0] lead;
    logic              uniform;
    logic              text;
    logic [7:0]        disk;
    logic [1:0]        nontext;
    logic [7:0]        cand;
    logic              any_uniform;
  } scan_state_t;

  localparam scan_state_t SCAN_IDLE = '{
    at_start: 1'b1, lead: '0, uniform: 1'b1, text: 1'b1,
    disk: '0, nontext: '0, cand: '0, any_uniform: 1'b0
  };

  // Kinds of disk block the random stripes are built from.
  typedef enum int {BLK_TEXT, BLK_BINARY, BLK_FLAT} blk_kind_t;

  // A row of the directed table. Where typed is set, the verdict in the row
  // is what the stripe must give; the other rows go through the predictor.
  typedef struct packed {
    logic [DATA_W-1:0]     word;
    logic                  blk_last;
    logic                  dsk_last;
    logic [TAG_W-1:0]      stripe;
    logic                  typed;
    logic                  found;
    logic [DISK_OUT_W-1:0] disk;
    logic [TAG_W-1:0]      tag;
  } dir_row_t;

  localparam int unsigned DIRECTED_ROWS = 26;
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Straight after reset: one disk of a single word. That block is
    // trivially uniform, so nothing can be found.
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0, 4'd0, 32'h0000_0000},
    // Two disks, the second the only non-text block, at the tag's top value.
    '{32'h4142_4344, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h4546_4748, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd1, 32'hFFFF_FFFF},
    // Printable edges: disk 0 sits exactly on 0x20 and 0x7E, disks 1 and 2
    // each have one byte just outside. Two non-text blocks give no answer.
    '{32'h2020_7E7E, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h7E7E_2020, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h1F20_2020, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h2020_2020, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h2020_207F, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h2020_2020, 1'b1, 1'b1, 32'h1234_5678, 1'b1, 1'b0, 4'd0, 32'h1234_5678},
    // A disk_last on a middle word must be ignored; every block is text.
    '{32'h6162_6364, 1'b0, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h6566_6768, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h3031_3233, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h3435_3637, 1'b1, 1'b1, 32'h0000_ABCD, 1'b0, 1'b0, 4'd0, 32'h0},
    // A uniform block hides the single non-text disk.
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h8081_8283, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h0102_0304, 1'b1, 1'b1, 32'h8000_0001, 1'b1, 1'b0, 4'd0, 32'h8000_0001},
    // Three disks with parity on disk 0, whose words differ only at the end.
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h4141_4141, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h4141_4142, 1'b1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h7A7A_7A7A, 1'b0, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 4'd0, 32'h0},
    '{32'h2020_2021, 1'b1, 1'b1, 32'h5A5A_5A5A, 1'b0, 1'b0, 4'd0, 32'h0}
  };

  scan_state_t scan = SCAN_IDLE;
  locate_t     pending_locs [$];
  int unsigned words_sent = 0;
  int unsigned fail_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // True when all four bytes lie in the printable range.
  function automatic bit all_printable(input logic [DATA_W-1:0] w);
    logic [7:0] b;
    for (int k = 0; k < 4; k++) begin
      b = w[8*k +: 8];
      if (b < PRINT_LO || b > PRINT_HI) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Predictor. Folds one transferred word into the scan state and returns 1
  // with the verdict in loc when the word closes a stripe.
  function automatic bit scan_word(input logic [DATA_W-1:0] w, input logic bl,
                                   input logic dl, input logic [TAG_W-1:0] sn,
                                   output locate_t loc);
    loc = '0;
    if (scan.at_start) begin
      scan.lead     = w;
      scan.at_start = 1'b0;
    end else if (w != scan.lead) begin
      scan.uniform = 1'b0;
    end
    if (!all_printable(w)) begin
      scan.text = 1'b0;
    end
    if (!bl) begin
      return 1'b0;
    end

    // The block is complete: tally it against the stripe.
    if (scan.uniform) begin
      scan.any_uniform = 1'b1;
    end else if (!scan.text) begin
      if (scan.nontext < 2) begin
        scan.nontext++;
      end
      scan.cand = scan.disk;
    end
    if (scan.disk < MAX_DISKS - 1) begin
      scan.disk++;
    end
    scan.at_start = 1'b1;
    scan.lead     = '0;
    scan.uniform  = 1'b1;
    scan.text     = 1'b1;
    if (!dl) begin
      return 1'b0;
    end

    loc.found = !scan.any_uniform && scan.nontext == 2'd1;
    loc.disk  = loc.found ? scan.cand[DISK_OUT_W-1:0] : '0;
    loc.tag   = sn;
    scan = SCAN_IDLE;
    return 1'b1;
  endfunction

  // Idle stretch length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] text_word();
    logic [DATA_W-1:0] w;
    for (int k = 0; k < 4; k++) begin
      w[8*k +: 8] = 8'($urandom_range(32'h20, 32'h7E));
    end
    return w;
  endfunction

  // A word with at least one byte outside the printable range, or, now and
  // then, a fully random one.
  function automatic logic [DATA_W-1:0] binary_word();
    logic [DATA_W-1:0] w;
    int unsigned lane;
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    w    = text_word();
    lane = $urandom_range(0, 3);
    w[8*lane +: 8] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 32'h1F))
                                                 : 8'($urandom_range(32'h7F, 32'hFF));
    return w;
  endfunction

  // Offers one word after a random gap (none when tight), holds it until the
  // block takes it, then runs the predictor. A row from the directed table
  // may supply its own verdict in place of the predicted one.
  task automatic send_word(input logic [DATA_W-1:0] w, input logic bl, input logic dl,
                           input logic [TAG_W-1:0] sn, input bit tight,
                           input bit typed, input locate_t typed_loc);
    int unsigned gap;
    locate_t loc;
    gap = tight ? 0 : idle_len();
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_word     <= w;
    in_ch.block_last    <= bl;
    in_ch.disk_last     <= dl;
    in_ch.stripe_number <= sn;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    words_sent++;
    if (scan_word(w, bl, dl, sn, loc)) begin
      pending_locs.push_back(typed ? typed_loc : loc);
    end
  endtask

  // One random stripe. Most are well formed: a chosen parity disk carries
  // binary data and the rest are text, sometimes spoiled by a second binary
  // block or a uniform one. A few are noise with markers thrown in at random.
  // Stripe numbers change on every word so that only the final one counts.
  task automatic send_stripe();
    int unsigned shape, n_disks, n_words, parity, bad_k;
    int          extra_bin, flat_disk;
    bit          tight, bl, dl;
    blk_kind_t   kind;
    logic [DATA_W-1:0] flat_w, w;

    tight = ($urandom_range(0, 3) == 0);
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      n_words = $urandom_range(1, 12);
      for (int k = 0; k < n_words; k++) begin
        bl = (k == n_words - 1) || ($urandom_range(0, 3) == 0);
        dl = (k == n_words - 1) || (!bl && $urandom_range(0, 1) == 1);
        send_word($urandom, bl, dl, $urandom, tight, 1'b0, '0);
      end
      return;
    end

    if (shape < 13) begin
      n_disks = 1;
    end else if (shape < 88) begin
      n_disks = $urandom_range(2, 6);
    end else if (shape < 95) begin
      n_disks = $urandom_range(7, 14);
    end else begin
      // Sometimes more disks than the index can count: the tail shares the top index.
      n_disks = $urandom_range(15, 20);
    end
    parity    = $urandom_range(0, n_disks - 1);
    extra_bin = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, n_disks - 1)) : -1;
    flat_disk = ($urandom_range(0, 99) < 10) ? int'($urandom_range(0, n_disks - 1)) : -1;

    for (int d = 0; d < n_disks; d++) begin
      if (d == flat_disk) begin
        kind = BLK_FLAT;
      end else if (d == parity || d == extra_bin) begin
        kind = BLK_BINARY;
      end else begin
        kind = BLK_TEXT;
      end
      n_words = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, 5);
      bad_k   = $urandom_range(0, n_words - 1);
      flat_w  = ($urandom_range(0, 1) == 0) ? text_word() : $urandom;
      for (int k = 0; k < n_words; k++) begin
        case (kind)
          BLK_FLAT: begin
            w = flat_w;
          end
          BLK_BINARY: begin
            w = (k == bad_k || $urandom_range(0, 2) == 0) ? binary_word() : text_word();
          end
          default: begin
            w = text_word();
          end
        endcase
        bl = (k == n_words - 1);
        dl = bl ? (d == n_disks - 1) : ($urandom_range(0, 9) == 0);
        send_word(w, bl, dl, $urandom, tight, 1'b0, '0);
      end
    end
  endtask

  // Stimulus: reset, the directed table, then random stripes until enough
  // words have gone in; afterwards wait for every verdict and a short drain.
  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_word     <= '0;
    in_ch.block_last    <= 1'b0;
    in_ch.disk_last     <= 1'b0;
    in_ch.stripe_number <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      send_word(DIRECTED[row].word, DIRECTED[row].blk_last, DIRECTED[row].dsk_last,
                DIRECTED[row].stripe, 1'b0, DIRECTED[row].typed,
                {DIRECTED[row].found, DIRECTED[row].disk, DIRECTED[row].tag});
    end
    while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
      send_stripe();
    end
    in_ch.valid <= 1'b0;

    while (pending_locs.size() != 0) begin
      @(posedge clk);
    end
    // Anything that shows up during the drain is flagged as unexpected.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Result side back-pressure: bursts of ready broken by stalls of random
  // length. Every so often one long hold-off lets the block fill up and push
  // back on the word stream while the sender keeps offering.
  initial begin
    int unsigned bursts;
    int unsigned stall;
    bursts = 0;
    out_ch.ready <= 1'b0;
    do begin
      @(posedge clk);
    end while (!rst_n);
    forever begin
      repeat ($urandom_range(1, 16)) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
      bursts++;
      stall = (bursts % 150 == 40) ? HOLD_CYCLES : idle_len();
      repeat (stall) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Each result transfer is matched against the oldest verdict waiting.
  always @(posedge clk) begin : check_results
    locate_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_locs.size() == 0) begin
        note_fail($sformatf("result with none expected: found=%0b disk=%0d tag=%h",
                            out_ch.parity_found, out_ch.parity_disk, out_ch.stripe_tag));
      end else begin
        want = pending_locs.pop_front();
        if (out_ch.parity_found !== want.found || out_ch.parity_disk !== want.disk ||
            out_ch.stripe_tag !== want.tag) begin
          note_fail($sformatf(
            "mismatch: found exp %0b got %0b, disk exp %0d got %0d, tag exp %h got %h",
            want.found, out_ch.parity_found, want.disk, out_ch.parity_disk,
            want.tag, out_ch.stripe_tag));
        end
      end
    end
  end

  // Watchdog: gives up once neither channel has moved a transfer for too long,
  // which also catches verdicts that never arrive.
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("testbench: errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/rspdl_pkg.sv
rtl/core/rspdl_if.sv
rtl/core/raid_stripe_parity_disk_locator_unit.sv
tb/testbench.sv
